[sv/pva_pkg.sv]
package pva_pkg;

    localparam int VOICE_COUNT = 5;
    localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int SCORE_W = 18;
    localparam int STAMP_W = 32;

    typedef logic [IDX_W-1:0]   t_vidx;
    typedef logic [SCORE_W-1:0] t_score;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_STATUS   = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_FREE    = 2'd0,
        KIND_RETRIG  = 2'd1,
        KIND_STOLEN  = 2'd2,
        KIND_ALL     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    localparam logic [2:0] REG_UNISON = 3'd0;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [2:0]  voice_select;
        logic        status_active;
        logic        status_releasing;
        logic [15:0] status_level;
    } t_item;

    typedef struct packed {
        logic [2:0]         voice_index;
        logic               command;
        logic [6:0]         note_out;
        logic [6:0]         velocity_out;
        logic [STAMP_W-1:0] trigger_stamp;
        logic [1:0]         assign_kind;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [6:0]  note;
        logic        active;
        logic        releasing;
        logic [15:0] level;
    } t_voice;

    typedef struct packed {
        logic   held;
        logic   free;
        logic   rel_hit;
        logic   better;
        t_score score;
    } t_scan;

    function automatic logic [2:0] vidx_out(t_vidx idx);
        logic [IDX_W+2:0] ext;
        ext = (IDX_W+3)'(idx);
        return ext[2:0];
    endfunction

endpackage

[sv/pva_scan_unit.sv]
module pva_scan_unit (
    input  pva_pkg::t_voice i_voice,
    input  logic [6:0]      i_note,
    input  pva_pkg::t_score i_best,
    output pva_pkg::t_scan  o_scan
);
    import pva_pkg::*;

    logic   note_eq;
    t_score score;

    assign note_eq = (i_voice.note == i_note);
    assign score   = i_voice.releasing ? {2'b00, i_voice.level} : {2'b10, i_voice.level};

    always_comb begin
        o_scan.held    = i_voice.active && note_eq;
        o_scan.free    = !i_voice.active;
        o_scan.rel_hit = i_voice.active && !i_voice.releasing && note_eq;
        o_scan.better  = (score < i_best);
        o_scan.score   = score;
    end

endmodule

[sv/poly_voice_allocator.sv]
// Voice allocator for a five-voice synthesizer. Raise start with a word on i_item while
// busy is low; a status word is applied at once and leaves busy low, a note word holds
// busy high while it steps through each voice in turn on the shared compare unit and
// then issues its last result, picking a voice for a poly note-on, and a poly note-off
// stops at its first matching voice; the final result of a word shows as busy falls.
// Results appear on o_result for exactly one cycle with o_valid high, in order, the final
// one of a word marked by last; the receiver cannot stall them, so it must take every
// strobed word. unison_on sits at address 0 of the APB port, decoded from paddr[2] alone;
// the user must write it only while the block is idle; the block itself does not enforce it.
module poly_voice_allocator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  pva_pkg::t_item   i_item,
    output logic             o_valid,
    output pva_pkg::t_result o_result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pva_pkg::*;

    t_state r_state, n_state;
    logic   scan_en, fin_en;

    t_voice r_voice [VOICE_COUNT];
    logic [STAMP_W-1:0] r_stamp, n_stamp;
    logic   r_unison;

    t_item  r_item, n_item;
    t_vidx  r_idx, n_idx;
    logic   r_match_v, n_match_v;
    t_vidx  r_match_idx, n_match_idx;
    logic   r_free_v, n_free_v;
    t_vidx  r_free_idx, n_free_idx;
    t_score r_best, n_best;
    t_vidx  r_best_idx, n_best_idx;
    logic    r_pend_v, n_pend_v;
    t_result r_pend, n_pend;
    logic    r_out_v, n_out_v;
    t_result r_out, n_out;

    logic   w_en, w_lvl_en;
    t_vidx  w_idx;
    t_voice w_voice;

    t_voice cur;
    t_scan  sc;
    logic   accept, last_idx, cfg_wr;
    t_vidx  pick_idx;
    t_kind  pick_kind;

    assign accept   = start && !busy;
    assign cur      = r_voice[r_idx];
    assign last_idx = (r_idx == t_vidx'(VOICE_COUNT - 1));
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_UNISON[2]) ? {31'b0, r_unison} : 32'b0;

    pva_scan_unit u_scan (
        .i_voice (cur),
        .i_note  (r_item.note),
        .i_best  (r_best),
        .o_scan  (sc)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.operation == OP_NOTE_ON ||
                               i_item.operation == OP_NOTE_OFF)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_idx || (r_item.operation == OP_NOTE_OFF && !r_unison && sc.rel_hit))
                begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy    = 1'b1;
        scan_en = 1'b0;
        fin_en  = 1'b0;
        unique case (r_state)
            ST_IDLE:   busy    = 1'b0;
            ST_SCAN:   scan_en = 1'b1;
            ST_FINISH: fin_en  = 1'b1;
            default:   busy    = 1'b1;
        endcase
    end

    always_comb begin
        if (r_match_v) begin
            pick_idx  = r_match_idx;
            pick_kind = KIND_RETRIG;
        end else if (r_free_v) begin
            pick_idx  = r_free_idx;
            pick_kind = KIND_FREE;
        end else begin
            pick_idx  = r_best_idx;
            pick_kind = KIND_STOLEN;
        end
    end

    always_comb begin
        n_item      = r_item;
        n_idx       = r_idx;
        n_match_v   = r_match_v;
        n_match_idx = r_match_idx;
        n_free_v    = r_free_v;
        n_free_idx  = r_free_idx;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_pend_v    = r_pend_v;
        n_pend      = r_pend;
        n_stamp     = r_stamp;
        n_out_v     = 1'b0;
        n_out       = r_out;
        w_en        = 1'b0;
        w_lvl_en    = 1'b0;
        w_idx       = r_idx;
        w_voice     = cur;

        if (accept) begin
            n_item    = i_item;
            n_idx     = '0;
            n_match_v = 1'b0;
            n_free_v  = 1'b0;
            n_best    = '1;
            n_pend_v  = 1'b0;
            if (i_item.operation == OP_STATUS && 32'(i_item.voice_select) < VOICE_COUNT) begin
                w_en     = 1'b1;
                w_lvl_en = 1'b1;
                w_idx    = t_vidx'(i_item.voice_select);
                w_voice  = '{note: r_voice[t_vidx'(i_item.voice_select)].note,
                             active: i_item.status_active,
                             releasing: i_item.status_releasing,
                             level: i_item.status_level};
            end
        end

        if (scan_en) begin
            n_idx = r_idx + t_vidx'(1);
            if (r_item.operation == OP_NOTE_ON) begin
                if (r_unison) begin
                    w_en     = 1'b1;
                    w_voice  = '{note: r_item.note, active: 1'b1, releasing: 1'b0,
                                 level: cur.level};
                    n_stamp  = r_stamp + 1'b1;
                    n_out_v  = r_pend_v;
                    n_out    = r_pend;
                    n_pend_v = 1'b1;
                    n_pend   = '{voice_index: vidx_out(r_idx), command: CMD_START,
                                 note_out: r_item.note, velocity_out: r_item.velocity,
                                 trigger_stamp: r_stamp + 1'b1, assign_kind: KIND_ALL,
                                 last: 1'b0};
                end else begin
                    if (sc.held && !r_match_v) begin
                        n_match_v   = 1'b1;
                        n_match_idx = r_idx;
                    end
                    if (sc.free && !r_free_v) begin
                        n_free_v   = 1'b1;
                        n_free_idx = r_idx;
                    end
                    if (sc.better) begin
                        n_best     = sc.score;
                        n_best_idx = r_idx;
                    end
                end
            end else if (sc.rel_hit) begin
                w_en     = 1'b1;
                w_voice  = '{note: cur.note, active: cur.active, releasing: 1'b1,
                             level: cur.level};
                n_out_v  = r_pend_v;
                n_out    = r_pend;
                n_pend_v = 1'b1;
                n_pend   = '{voice_index: vidx_out(r_idx), command: CMD_RELEASE,
                             note_out: r_item.note, velocity_out: 7'd0,
                             trigger_stamp: '0, assign_kind: KIND_ALL, last: 1'b0};
            end
        end

        if (fin_en) begin
            if (r_item.operation == OP_NOTE_ON && !r_unison) begin
                w_en    = 1'b1;
                w_idx   = pick_idx;
                w_voice = '{note: r_item.note, active: 1'b1, releasing: 1'b0,
                            level: cur.level};
                n_stamp = r_stamp + 1'b1;
                n_out_v = 1'b1;
                n_out   = '{voice_index: vidx_out(pick_idx), command: CMD_START,
                            note_out: r_item.note, velocity_out: r_item.velocity,
                            trigger_stamp: r_stamp + 1'b1, assign_kind: pick_kind,
                            last: 1'b1};
            end else begin
                n_out_v    = r_pend_v;
                n_out      = r_pend;
                n_out.last = 1'b1;
            end
            n_pend_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_stamp  <= '0;
            r_unison <= 1'b0;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
            for (int i = 0; i < VOICE_COUNT; i++) begin
                r_voice[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_stamp  <= n_stamp;
            r_out_v  <= n_out_v;
            r_pend_v <= n_pend_v;
            if (cfg_wr && paddr[2] == REG_UNISON[2]) begin
                r_unison <= pwdata[0];
            end
            if (w_en) begin
                r_voice[w_idx].note      <= w_voice.note;
                r_voice[w_idx].active    <= w_voice.active;
                r_voice[w_idx].releasing <= w_voice.releasing;
                if (w_lvl_en) begin
                    r_voice[w_idx].level <= w_voice.level;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_idx       <= n_idx;
        r_match_v   <= n_match_v;
        r_match_idx <= n_match_idx;
        r_free_v    <= n_free_v;
        r_free_idx  <= n_free_idx;
        r_best      <= n_best;
        r_best_idx  <= n_best_idx;
        r_pend      <= n_pend;
        r_out       <= n_out;
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

[sv/pva_checker.sv]
module pva_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input pva_pkg::t_item   i_item,
    input logic             o_valid,
    input pva_pkg::t_result o_result
);
    import pva_pkg::*;

    a_note_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.operation == OP_NOTE_ON ||
                            i_item.operation == OP_NOTE_OFF)) |=> busy)
        else $error("note word did not hold busy");

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result right after accept");

    a_release_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.command == CMD_RELEASE) |->
        (o_result.velocity_out == 7'd0 && o_result.trigger_stamp == '0 &&
         o_result.assign_kind == KIND_ALL))
        else $error("release word carries start fields");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |=> !o_valid)
        else $error("result after last");

    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |-> busy)
        else $error("non-final result while idle");

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);
